### sv/ordered_small_set_engine_unit_defines.svh
// Assertion macros for the ordered small-set engine.
`ifndef ORDERED_SMALL_SET_ENGINE_UNIT_DEFINES_SVH
`define ORDERED_SMALL_SET_ENGINE_UNIT_DEFINES_SVH

// Same-cycle implication, sampled on clk, off while in reset.
`define OSS_ASSERT_NOW(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error(msg);

// Next-cycle implication.
`define OSS_ASSERT_NEXT(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

### sv/oss_pkg.sv
// Shared types and codes for the ordered small-set engine.
package oss_pkg;

	localparam int VAL_W = 6;
	localparam int CMD_W = 3;
	localparam int KIND_W = 2;
	localparam int MAX_VALUE_DEF = 32;

	localparam logic [CMD_W-1:0] CMD_ADD = 3'd0;
	localparam logic [CMD_W-1:0] CMD_REMOVE = 3'd1;
	localparam logic [CMD_W-1:0] CMD_CHECK = 3'd2;
	localparam logic [CMD_W-1:0] CMD_TOGGLE = 3'd3;
	localparam logic [CMD_W-1:0] CMD_ALL = 3'd4;
	localparam logic [CMD_W-1:0] CMD_EMPTY = 3'd5;

	localparam logic [KIND_W-1:0] KIND_ANSWER = 2'd0;
	localparam logic [KIND_W-1:0] KIND_MEMBER = 2'd1;
	localparam logic [KIND_W-1:0] KIND_EMPTY = 2'd2;
	localparam logic [KIND_W-1:0] KIND_ERROR = 2'd3;

	typedef enum logic [2:0] {
		ST_IDLE,
		ST_ERROR,
		ST_ANSWER,
		ST_SEARCH,
		ST_SHIFT,
		ST_FILL,
		ST_LIST
	} state_t;

endpackage

### sv/ordered_small_set_engine_unit.sv
// Ordered small-set engine: bitmap plus insertion-ordered member list in one RAM.
`include "ordered_small_set_engine_unit_defines.svh"

// One command beat is taken when the engine is idle; it then emits its result beats
// (error, answer, listing) through a single output register. The listing reads the
// order-list RAM through its one read port at one member per cycle while the output
// is not stalled; an add, toggle, remove or empty lists the whole set after the
// operation, and a check gives its answer beat before that listing (an empty set
// still gives one beat). A remove or toggle of a member first scans the list for it
// and then shifts the tail back through the same port. The all command writes every
// value from 1 to MAX_VALUE into the list before listing. An error gives a single
// beat and no listing. Output back-pressure stalls the answer, error and listing
// beats. The RAM needs no clearing pass: only entries below the count are ever read.
module ordered_small_set_engine_unit
	import oss_pkg::*;
#(
	parameter int MAX_VALUE = MAX_VALUE_DEF
) (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              cmd_valid,
	output logic              cmd_ready,
	input  logic [CMD_W-1:0]  command,
	input  logic [VAL_W-1:0]  operand,
	output logic              res_valid,
	input  logic              res_ready,
	output logic [KIND_W-1:0] kind,
	output logic [VAL_W-1:0]  element,
	output logic              member,
	output logic              last
);

	localparam int AW = $clog2(MAX_VALUE);
	localparam int CW = $clog2(MAX_VALUE + 1);
	localparam logic [CW-1:0] CNT_MAX = CW'(MAX_VALUE);
	localparam logic [AW-1:0] ADDR_LAST = AW'(MAX_VALUE - 1);

	state_t state_q, state_d;

	logic [MAX_VALUE-1:0] bits_q;
	logic [CW-1:0]        count_q;
	logic [CW-1:0]        r_q;
	logic [CW-1:0]        w_q;
	logic [AW-1:0]        f_q;
	logic                 pend_q;
	logic [VAL_W-1:0]     op_q;

	logic [VAL_W-1:0] mem [MAX_VALUE];
	logic [VAL_W-1:0] mem_rd_q;

	logic              res_valid_q;
	logic [KIND_W-1:0] kind_q;
	logic [VAL_W-1:0]  element_q;
	logic              member_q;
	logic              last_q;

	// decode of the incoming beat
	logic             accept;
	logic [VAL_W-1:0] in_vm1;
	logic [AW-1:0]    in_idx;
	logic             in_present;
	logic             in_bad;
	logic [VAL_W-1:0] op_vm1;
	logic [AW-1:0]    op_idx;

	// datapath controls
	logic              slot_free;
	logic              rd_en;
	logic [AW-1:0]     rd_addr;
	logic              wr_en;
	logic [AW-1:0]     wr_addr;
	logic [VAL_W-1:0]  wr_data;
	logic              do_add;
	logic              do_drop;
	logic              do_fill_end;
	logic              do_clear;
	logic              r_clr;
	logic              r_inc;
	logic              pend_d;
	logic              w_load;
	logic              w_inc;
	logic              f_inc;
	logic              ld;
	logic [KIND_W-1:0] ld_kind;
	logic [VAL_W-1:0]  ld_element;
	logic              ld_member;
	logic              ld_last;
	logic              hit;
	logic              shift_more;

	assign cmd_ready = (state_q == ST_IDLE);
	assign accept = cmd_valid && cmd_ready;
	assign slot_free = !res_valid_q || res_ready;

	assign in_vm1 = operand - VAL_W'(1);
	assign in_idx = in_vm1[AW-1:0];
	assign op_vm1 = op_q - VAL_W'(1);
	assign op_idx = op_vm1[AW-1:0];
	assign in_bad = (command > CMD_EMPTY) ||
		((command <= CMD_TOGGLE) &&
		 ((operand == VAL_W'(0)) || (operand > VAL_W'(MAX_VALUE))));
	assign in_present = bits_q[in_idx];

	assign hit = pend_q && (mem_rd_q == op_q);
	assign shift_more = (w_q + CW'(1)) < count_q;

	// next state
	always_comb begin
		state_d = state_q;
		case (state_q)
			ST_IDLE: begin
				if (accept) begin
					if (in_bad) begin
						state_d = ST_ERROR;
					end else begin
						case (command)
							CMD_CHECK: state_d = ST_ANSWER;
							CMD_ALL: state_d = ST_FILL;
							CMD_REMOVE, CMD_TOGGLE:
								state_d = in_present ? ST_SEARCH : ST_LIST;
							default: state_d = ST_LIST;
						endcase
					end
				end
			end
			ST_ERROR: begin
				if (slot_free) state_d = ST_IDLE;
			end
			ST_ANSWER: begin
				if (slot_free) state_d = ST_LIST;
			end
			ST_SEARCH: begin
				if (hit) state_d = ST_SHIFT;
			end
			ST_SHIFT: begin
				if (!shift_more) state_d = ST_LIST;
			end
			ST_FILL: begin
				if (f_q == ADDR_LAST) state_d = ST_LIST;
			end
			ST_LIST: begin
				if (ld && ld_last) state_d = ST_IDLE;
			end
			default: state_d = ST_IDLE;
		endcase
	end

	// controls per state
	always_comb begin
		rd_en = 1'b0;
		rd_addr = r_q[AW-1:0];
		wr_en = 1'b0;
		wr_addr = count_q[AW-1:0];
		wr_data = operand;
		do_add = 1'b0;
		do_drop = 1'b0;
		do_fill_end = 1'b0;
		do_clear = 1'b0;
		r_clr = 1'b1;
		r_inc = 1'b0;
		pend_d = 1'b0;
		w_load = 1'b0;
		w_inc = 1'b0;
		f_inc = 1'b0;
		ld = 1'b0;
		ld_kind = KIND_MEMBER;
		ld_element = '0;
		ld_member = 1'b0;
		ld_last = 1'b0;
		case (state_q)
			ST_IDLE: begin
				if (accept && !in_bad) begin
					case (command)
						CMD_ADD: do_add = !in_present;
						CMD_TOGGLE: do_add = !in_present;
						CMD_EMPTY: do_clear = 1'b1;
						default: ;
					endcase
				end
				// append goes to the slot just past the list
				wr_en = do_add;
			end
			ST_ERROR: begin
				ld = slot_free;
				ld_kind = KIND_ERROR;
				ld_last = 1'b1;
			end
			ST_ANSWER: begin
				ld = slot_free;
				ld_kind = KIND_ANSWER;
				ld_member = bits_q[op_idx];
			end
			ST_SEARCH: begin
				// read one entry a cycle, compare the one read last cycle
				r_clr = 1'b0;
				rd_en = r_q < count_q;
				r_inc = rd_en;
				pend_d = rd_en;
				w_load = hit;
			end
			ST_SHIFT: begin
				// mem_rd_q holds entry w+1; move it down to w
				if (shift_more) begin
					r_clr = 1'b0;
					wr_en = 1'b1;
					wr_addr = w_q[AW-1:0];
					wr_data = mem_rd_q;
					w_inc = 1'b1;
					rd_en = r_q < count_q;
					r_inc = rd_en;
					pend_d = rd_en;
				end else begin
					do_drop = 1'b1;
				end
			end
			ST_FILL: begin
				wr_en = 1'b1;
				wr_addr = f_q;
				wr_data = VAL_W'(f_q) + VAL_W'(1);
				f_inc = 1'b1;
				do_fill_end = (f_q == ADDR_LAST);
			end
			ST_LIST: begin
				if (count_q == CW'(0)) begin
					ld = slot_free;
					ld_kind = KIND_EMPTY;
					ld_last = 1'b1;
				end else begin
					r_clr = 1'b0;
					rd_en = (!pend_q || slot_free) && (r_q < count_q);
					r_inc = rd_en;
					ld = pend_q && slot_free;
					ld_element = mem_rd_q;
					ld_last = (r_q == count_q);
					pend_d = rd_en || (pend_q && !slot_free);
				end
			end
			default: ;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
			bits_q <= '0;
			count_q <= '0;
			r_q <= '0;
			w_q <= '0;
			f_q <= '0;
			pend_q <= 1'b0;
			res_valid_q <= 1'b0;
		end else begin
			state_q <= state_d;
			pend_q <= pend_d;
			if (r_clr) r_q <= '0;
			else if (r_inc) r_q <= r_q + CW'(1);
			if (w_load) w_q <= r_q - CW'(1);
			else if (w_inc) w_q <= w_q + CW'(1);
			if (state_q != ST_FILL) f_q <= '0;
			else if (f_inc) f_q <= f_q + AW'(1);
			if (do_add) begin
				bits_q[in_idx] <= 1'b1;
				count_q <= count_q + CW'(1);
			end else if (do_drop) begin
				bits_q[op_idx] <= 1'b0;
				count_q <= count_q - CW'(1);
			end else if (do_fill_end) begin
				bits_q <= '1;
				count_q <= CNT_MAX;
			end else if (do_clear) begin
				bits_q <= '0;
				count_q <= '0;
			end
			res_valid_q <= ld || (res_valid_q && !res_ready);
		end
	end

	always_ff @(posedge clk) begin
		if (accept) op_q <= operand;
		if (ld) begin
			kind_q <= ld_kind;
			element_q <= ld_element;
			member_q <= ld_member;
			last_q <= ld_last;
		end
	end

	// order-list RAM, one write and one registered read port
	always_ff @(posedge clk) begin
		if (wr_en) mem[wr_addr] <= wr_data;
		if (rd_en) mem_rd_q <= mem[rd_addr];
	end

	assign res_valid = res_valid_q;
	assign kind = kind_q;
	assign element = element_q;
	assign member = member_q;
	assign last = last_q;

	`OSS_ASSERT_NOW(a_count_bound, 1'b1, count_q <= CNT_MAX, "member count above maximum")
	`OSS_ASSERT_NOW(a_bits_match_count, 1'b1, $countones(bits_q) == int'(count_q),
		"bitmap population differs from member count")
	`OSS_ASSERT_NOW(a_shift_in_list, state_q == ST_SHIFT, w_q < count_q,
		"shift position past end of list")
	`OSS_ASSERT_NEXT(a_search_hits, state_q == ST_SEARCH && !hit && r_q == count_q,
		state_q == ST_SEARCH && hit, "search ran off the list without a match")

endmodule
